// ----- sv/stec_pkg.sv -----
// Shared types and constants for the slot table entry checker.
// No dependencies; imported by stec_class, stec_ctrl and the top level.
package stec_pkg;

  localparam int unsigned MaxSlots = 4096;
  localparam int unsigned AddrW    = $clog2(MaxSlots);
  localparam int unsigned CntW     = $clog2(MaxSlots + 1);
  localparam int unsigned FieldW   = 12;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [FieldW-1:0] FieldMax = '1;

  localparam logic [CfgIdxW-1:0] RegContainerSize = 1'b0;
  localparam logic [CfgIdxW-1:0] RegStringsBase   = 1'b1;

  localparam logic [1:0] ClsEmpty     = 2'd0;
  localparam logic [1:0] ClsResidue   = 2'd1;
  localparam logic [1:0] ClsRange     = 2'd2;
  localparam logic [1:0] ClsPopulated = 2'd3;

  localparam logic [1:0] NameNone   = 2'd0;
  localparam logic [1:0] NameRead   = 2'd1;
  localparam logic [1:0] NameRange  = 2'd2;
  localparam logic [1:0] NameNotApp = 2'd3;

  localparam int unsigned PopulatedBit = 0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLASS,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic        first;
    logic [31:0] payload_offset;
    logic [31:0] payload_size;
    logic [31:0] str_offset;
    logic [31:0] flags;
  } req_t;

  typedef struct packed {
    logic [1:0]  entry_class;
    logic [31:0] out_offset;
    logic [31:0] out_size;
    logic [1:0]  name_status;
    logic [32:0] name_address;
    logic [32:0] ivl_end;
  } cls_res_t;

  typedef struct packed {
    logic [31:0]       ivl_start;
    logic [32:0]       ivl_end;
    logic [FieldW-1:0] ivl_slot;
  } interval_t;

endpackage

// ----- sv/stec_class.sv -----
// Entry classification, range check and name resolution.
// Depends on stec_pkg.
module stec_class (
  input  stec_pkg::req_t     req_i,
  input  logic [31:0]        container_size_i,
  input  logic [31:0]        strings_base_i,
  output stec_pkg::cls_res_t res_o
);
  import stec_pkg::*;

  logic [31:0] room;
  logic [32:0] naddr;

  always_comb begin
    room  = container_size_i - req_i.payload_offset;
    naddr = {1'b0, strings_base_i} + {1'b0, req_i.str_offset};
    res_o = '0;
    res_o.name_status = NameNotApp;
    if (!req_i.flags[PopulatedBit]) begin
      res_o.entry_class = ((req_i.payload_offset != '0) || (req_i.payload_size != '0) ||
                           (req_i.str_offset != '0)) ? ClsResidue : ClsEmpty;
    end else if ((req_i.payload_size == '0) || (req_i.payload_offset > container_size_i) ||
                 (req_i.payload_size > room)) begin
      res_o.entry_class = ClsRange;
    end else begin
      res_o.entry_class = ClsPopulated;
      res_o.out_offset  = req_i.payload_offset;
      res_o.out_size    = req_i.payload_size;
      res_o.ivl_end     = {1'b0, req_i.payload_offset} + {1'b0, req_i.payload_size};
      if ((req_i.str_offset == '0) || (strings_base_i > container_size_i)) begin
        res_o.name_status = NameNone;
      end else begin
        res_o.name_address = naddr;
        res_o.name_status  = (naddr > {1'b0, container_size_i}) ? NameRange : NameRead;
      end
    end
  end

endmodule

// ----- sv/stec_ctrl.sv -----
// Sequencer, slot counters, interval memory and overlap scan.
// Depends on stec_pkg; takes classification from stec_class.
module stec_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  stec_pkg::req_t         req_i,
  output stec_pkg::req_t         req_o,
  input  stec_pkg::cls_res_t     cls_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [11:0]            slot_number_o,
  output stec_pkg::cls_res_t     cls_o,
  output logic [11:0]            overlap_count_o,
  output logic [11:0]            first_overlap_slot_o,
  output logic                   slot_limit_hit_o
);
  import stec_pkg::*;

  state_e            state_q, state_d;
  logic [CntW-1:0]   slot_cnt_q, slot_cnt_d;
  logic [CntW-1:0]   stored_q, stored_d;
  logic [CntW-1:0]   slot_q, slot_d;
  logic              over_q, over_d;
  logic [CntW-1:0]   rd_ptr_q, rd_ptr_d;
  logic              pend_q, pend_d;
  logic              done_q, done_d;
  logic [FieldW-1:0] ovl_cnt_q, ovl_cnt_d;
  logic [FieldW-1:0] ovl_first_q, ovl_first_d;
  req_t              req_q, req_d;
  cls_res_t          cls_q, cls_d;

  interval_t         mem [MaxSlots];
  interval_t         rdata_q;
  interval_t         wdata;
  logic              re, we;
  logic [AddrW-1:0]  raddr, waddr;

  logic              accept, issue, hit;
  logic [CntW-1:0]   slot_new;

  assign accept   = (state_q == ST_IDLE) && start_i;
  assign issue    = (state_q == ST_SCAN) && (rd_ptr_q < stored_q);
  assign slot_new = req_i.first ? '0 : slot_cnt_q;
  assign hit      = pend_q && ({1'b0, rdata_q.ivl_start} < cls_q.ivl_end) &&
                    ({1'b0, req_q.payload_offset} < rdata_q.ivl_end);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_CLASS;
      ST_CLASS: state_d = (cls_i.entry_class == ClsPopulated) ? ST_SCAN : ST_IDLE;
      ST_SCAN:  if (!issue) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    slot_cnt_d  = slot_cnt_q;
    stored_d    = stored_q;
    slot_d      = slot_q;
    over_d      = over_q;
    rd_ptr_d    = rd_ptr_q;
    pend_d      = issue;
    done_d      = 1'b0;
    ovl_cnt_d   = ovl_cnt_q;
    ovl_first_d = ovl_first_q;
    req_d       = req_q;
    cls_d       = cls_q;
    re          = issue;
    raddr       = rd_ptr_q[AddrW-1:0];
    we          = 1'b0;
    waddr       = stored_q[AddrW-1:0];
    wdata       = '{ivl_start: req_q.payload_offset, ivl_end: cls_q.ivl_end,
                    ivl_slot: slot_q[FieldW-1:0]};
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d       = req_i;
          slot_d      = slot_new;
          over_d      = (slot_new >= CntW'(MaxSlots));
          slot_cnt_d  = (slot_new >= CntW'(MaxSlots)) ? slot_new : slot_new + 1'b1;
          if (req_i.first) stored_d = '0;
          ovl_cnt_d   = '0;
          ovl_first_d = '0;
        end
      end
      ST_CLASS: begin
        cls_d    = cls_i;
        rd_ptr_d = '0;
        if (cls_i.entry_class != ClsPopulated) done_d = 1'b1;
      end
      ST_SCAN: begin
        if (issue) rd_ptr_d = rd_ptr_q + 1'b1;
        if (hit) begin
          if (ovl_cnt_q == '0) ovl_first_d = rdata_q.ivl_slot;
          if (ovl_cnt_q != FieldMax) ovl_cnt_d = ovl_cnt_q + 1'b1;
        end
        if (!issue) begin
          done_d = 1'b1;
          we     = !over_q && (stored_q < CntW'(MaxSlots));
          if (we) stored_d = stored_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      slot_cnt_q <= '0;
      stored_q   <= '0;
      pend_q     <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      slot_cnt_q <= slot_cnt_d;
      stored_q   <= stored_d;
      pend_q     <= pend_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q      <= slot_d;
    over_q      <= over_d;
    rd_ptr_q    <= rd_ptr_d;
    ovl_cnt_q   <= ovl_cnt_d;
    ovl_first_q <= ovl_first_d;
    req_q       <= req_d;
    cls_q       <= cls_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (re) rdata_q <= mem[raddr];
  end

  assign req_o                = req_q;
  assign busy_o               = (state_q != ST_IDLE);
  assign done_o               = done_q;
  assign slot_number_o        = (slot_q > CntW'(FieldMax)) ? FieldMax : slot_q[FieldW-1:0];
  assign cls_o                = cls_q;
  assign overlap_count_o      = ovl_cnt_q;
  assign first_overlap_slot_o = ovl_first_q;
  assign slot_limit_hit_o     = over_q;

endmodule

// ----- sv/slot_table_entry_checker_unit.sv -----
// Top level of the slot table entry checker: configuration registers and ports.
// Depends on stec_pkg, stec_class and stec_ctrl.
//
// One request is taken when start_i is high and busy_o low; its result shows
// for exactly one cycle under done_o and must be taken then, since results
// cannot be held off; a new request may be taken at the edge that ends that
// cycle. A request that is not a populated, in-range entry ends after its
// classification. A populated entry scans the N intervals stored so far in
// the container (at most 4096): the interval memory is read one entry per
// cycle through its single read port, and the new interval is written back
// as the scan ends. No clearing pass is needed after reset.
module slot_table_entry_checker_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [stec_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          first_in_container_i,
  input  logic [31:0]                   payload_offset_i,
  input  logic [31:0]                   payload_size_i,
  input  logic [31:0]                   str_offset_i,
  input  logic [31:0]                   flags_i,
  output logic                          done_o,
  output logic [11:0]                   slot_number_o,
  output logic [1:0]                    entry_class_o,
  output logic [31:0]                   out_offset_o,
  output logic [31:0]                   out_size_o,
  output logic [1:0]                    name_status_o,
  output logic [32:0]                   name_address_o,
  output logic [11:0]                   overlap_count_o,
  output logic [11:0]                   first_overlap_slot_o,
  output logic                          slot_limit_hit_o
);
  import stec_pkg::*;

  logic [31:0] container_size_q;
  logic [31:0] strings_base_q;
  req_t        req_in, req_held;
  cls_res_t    cls_comb, cls_held;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      container_size_q <= '0;
      strings_base_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegContainerSize: container_size_q <= cfg_wdata_i;
        RegStringsBase:   strings_base_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign req_in = '{first: first_in_container_i, payload_offset: payload_offset_i,
                    payload_size: payload_size_i, str_offset: str_offset_i,
                    flags: flags_i};

  stec_class u_class (
    .req_i            (req_held),
    .container_size_i (container_size_q),
    .strings_base_i   (strings_base_q),
    .res_o            (cls_comb)
  );

  stec_ctrl u_ctrl (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_i              (start_i),
    .req_i                (req_in),
    .req_o                (req_held),
    .cls_i                (cls_comb),
    .busy_o               (busy_o),
    .done_o               (done_o),
    .slot_number_o        (slot_number_o),
    .cls_o                (cls_held),
    .overlap_count_o      (overlap_count_o),
    .first_overlap_slot_o (first_overlap_slot_o),
    .slot_limit_hit_o     (slot_limit_hit_o)
  );

  assign entry_class_o  = cls_held.entry_class;
  assign out_offset_o   = cls_held.out_offset;
  assign out_size_o     = cls_held.out_size;
  assign name_status_o  = cls_held.name_status;
  assign name_address_o = cls_held.name_address;

endmodule
